/* rtl/edf_pkg.sv */
// Package with shared types and codes for the EDF tick scheduler.
package edf_pkg;
	typedef enum logic [2:0] {
		EV_RUN      = 3'd0,
		EV_DISPATCH = 3'd1,
		EV_RESUME   = 3'd2,
		EV_PREEMPT  = 3'd3,
		EV_COMPLETE = 3'd4,
		EV_SWITCH   = 3'd5,
		EV_IDLE     = 3'd6,
		EV_ALLDONE  = 3'd7
	} event_t;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_SKIP,
		ST_DIV,
		ST_FIX,
		ST_WRITE,
		ST_OUT
	} state_t;
endpackage

/* rtl/edf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module edf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/edf_tick_scheduler.sv */
// Top level of the preemptive earliest-deadline-first tick scheduler.
//
// The scheduler keeps up to NUM_TASKS periodic tasks. A load item
// (operation 0) writes one slot and yields no result. A tick item
// (operation 1) advances time by one unit, except on all done, and yields
// exactly one result item: run, dispatch, resume, preempt, complete,
// switch, idle or all done. Per-slot period and execution time live in a
// RAM with registered read; the slot's dynamic fields (jobs left, release,
// deadline, time left, late mark) live in flip-flops so they read as zero
// after reset. A tick walks the slots one per cycle to find the released
// task with the earliest deadline (ties to the lowest slot). A switch tick
// needs no scan. When the finished job missed its deadline and its next
// release would still lie before the current time, the release catches up
// to the first period boundary at or after the current time; the distance
// modulo the period comes from a restoring remainder loop. A stalled result
// is held until the receiver takes it. Time values are TIME_BITS wide and
// wrap; the reported time is the low 32 bits. The missed total saturates
// at its maximum.
module edf_tick_scheduler
	import edf_pkg::*;
#(
	parameter int NUM_TASKS = 8,
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [2:0]  slot,
	input  logic [15:0] period,
	input  logic [15:0] exec_time,
	input  logic [15:0] job_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_res,
	output logic [2:0]  task_out,
	output logic [31:0] now,
	output logic        deadline_missed,
	output logic [15:0] missed_total
);
	localparam int SW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int CW = $clog2(NUM_TASKS + 1);
	localparam logic [CW-1:0] LAST = CW'(NUM_TASKS - 1);
	localparam int DW = (TIME_BITS > 1) ? $clog2(TIME_BITS) : 1;
	localparam logic [DW-1:0] DIV_LAST = DW'(TIME_BITS - 1);

	// Dynamic per-slot state.
	logic [15:0]          jobs_q [NUM_TASKS];
	logic [TIME_BITS-1:0] rel_q  [NUM_TASKS];
	logic [TIME_BITS-1:0] dl_q   [NUM_TASKS];
	logic [15:0]          tl_q   [NUM_TASKS];
	logic                 late_q [NUM_TASKS];

	logic                 run_v_q;
	logic [SW-1:0]        run_q;
	logic [TIME_BITS-1:0] clk_now_q;
	logic [15:0]          miss_q;
	logic                 sw_q;

	state_t state_q, state_d;

	logic [CW-1:0]        idx_q;
	logic                 best_v_q;
	logic [SW-1:0]        best_q;
	logic                 any_jobs_q;
	logic [SW-1:0]        tgt_q;
	logic [TIME_BITS-1:0] new_rel_q;
	logic [2:0]           ev_q;
	logic                 miss_flag_q;
	logic [2:0]           who_q;

	// Remainder loop for catching up a late release.
	logic [TIME_BITS-1:0] dvd_q;
	logic [15:0]          rem_q;
	logic [DW-1:0]        div_cnt_q;

	logic                 in_acc;
	logic                 ram_we;
	logic [SW-1:0]        ram_waddr, ram_raddr;
	logic [31:0]          ram_rdata;

	logic [15:0] per_r, exe_r;
	assign per_r = ram_rdata[31:16];
	assign exe_r = ram_rdata[15:0];

	// Period and execution time of each slot.
	edf_ram #(.WIDTH(32), .DEPTH(1 << SW)) u_param_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({period, exec_time}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign ram_we   = in_acc && operation == OP_LOAD && {1'b0, slot} < 4'(NUM_TASKS);
	assign ram_waddr = SW'(slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Candidate test for the slot under the scan index.
	logic [SW-1:0] sidx;
	logic          cand;
	assign sidx = SW'(idx_q);
	assign cand = (jobs_q[sidx] != 16'd0) && (rel_q[sidx] <= clk_now_q) &&
	              (!best_v_q || dl_q[sidx] < dl_q[best_q]);

	// Read address: the running slot ahead of a switch tick, and during the
	// scan with no slot running the best slot found so far, so that the
	// decision cycle sees the parameters of the slot it dispatches.
	always_comb begin
		ram_raddr = tgt_q;
		if (state_q == ST_IDLE) begin
			ram_raddr = run_q;
		end else if (state_q == ST_SCAN && !run_v_q) begin
			ram_raddr = cand ? sidx : best_q;
		end
	end

	logic [TIME_BITS-1:0] per_t, rel_next;
	assign per_t    = TIME_BITS'(per_r);
	assign rel_next = rel_q[tgt_q] + per_t;

	logic [TIME_BITS-1:0] now_inc;
	assign now_inc = clk_now_q + 1'b1;

	// Unit of execution for tgt_q (decided in ST_DECIDE).
	logic run_done, run_miss;
	assign run_done = tl_q[tgt_q] <= 16'd1;
	assign run_miss = dl_q[tgt_q] < now_inc;

	// A late job whose next release still lies in the past must catch up.
	logic skip_need;
	assign skip_need = late_q[tgt_q] && per_r != 16'd0 && new_rel_q < clk_now_q;

	// One restoring step of the remainder of (now - release) by the period.
	logic [16:0] rem_sh, rem_sub;
	logic [15:0] rem_next, catch_up;
	assign rem_sh   = {rem_q, dvd_q[TIME_BITS-1]};
	assign rem_sub  = rem_sh - {1'b0, per_r};
	assign rem_next = (rem_sh >= {1'b0, per_r}) ? rem_sub[15:0] : rem_sh[15:0];
	assign catch_up = (rem_q == 16'd0) ? 16'd0 : per_r - rem_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && operation == OP_TICK) begin
					state_d = sw_q ? ST_DECIDE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (idx_q == LAST) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: state_d = (sw_q && run_v_q) ? ST_SKIP : ST_OUT;
			ST_SKIP:   state_d = skip_need ? ST_DIV : ST_WRITE;
			ST_DIV: begin
				if (div_cnt_q == DIV_LAST) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX:   state_d = ST_WRITE;
			ST_WRITE: state_d = ST_OUT;
			ST_OUT: begin
				if (!out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				jobs_q[i] <= '0;
				rel_q[i]  <= '0;
				dl_q[i]   <= '0;
				tl_q[i]   <= '0;
				late_q[i] <= 1'b0;
			end
			run_v_q     <= 1'b0;
			run_q       <= '0;
			clk_now_q   <= '0;
			miss_q      <= '0;
			sw_q        <= 1'b0;
			idx_q       <= '0;
			best_v_q    <= 1'b0;
			best_q      <= '0;
			any_jobs_q  <= 1'b0;
			tgt_q       <= '0;
			new_rel_q   <= '0;
			ev_q        <= EV_RUN;
			miss_flag_q <= 1'b0;
			who_q       <= '0;
			dvd_q       <= '0;
			rem_q       <= '0;
			div_cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					idx_q      <= '0;
					best_v_q   <= 1'b0;
					any_jobs_q <= 1'b0;
					tgt_q      <= run_q;
					if (ram_we) begin
						jobs_q[SW'(slot)] <= job_count;
						rel_q[SW'(slot)]  <= '0;
						dl_q[SW'(slot)]   <= TIME_BITS'(period);
						tl_q[SW'(slot)]   <= exec_time;
						late_q[SW'(slot)] <= 1'b0;
						if (run_v_q && run_q == SW'(slot)) begin
							run_v_q <= 1'b0;
							sw_q    <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (jobs_q[sidx] != 16'd0) begin
						any_jobs_q <= 1'b1;
					end
					if (cand) begin
						best_v_q <= 1'b1;
						best_q   <= sidx;
					end
					if (!run_v_q) begin
						tgt_q <= cand ? sidx : best_q;
					end
				end
				ST_DECIDE: begin
					miss_flag_q <= 1'b0;
					if (sw_q) begin
						// Switch tick: finish the job of the running slot.
						clk_now_q <= now_inc;
						sw_q      <= 1'b0;
						ev_q      <= EV_SWITCH;
						who_q     <= run_v_q ? 3'(tgt_q) : 3'd0;
						new_rel_q <= rel_next;
					end else if (run_v_q && best_v_q && dl_q[best_q] < dl_q[run_q]) begin
						ev_q      <= EV_PREEMPT;
						who_q     <= 3'(run_q);
						run_v_q   <= 1'b0;
						clk_now_q <= now_inc;
					end else if (run_v_q || best_v_q) begin
						who_q     <= 3'(tgt_q);
						run_v_q   <= 1'b1;
						run_q     <= tgt_q;
						clk_now_q <= now_inc;
						if (run_done) begin
							tl_q[tgt_q] <= '0;
							ev_q        <= EV_COMPLETE;
							sw_q        <= 1'b1;
							if (run_miss) begin
								miss_flag_q   <= 1'b1;
								late_q[tgt_q] <= 1'b1;
								if (miss_q != 16'hFFFF) begin
									miss_q <= miss_q + 1'b1;
								end
							end
						end else begin
							tl_q[tgt_q] <= tl_q[tgt_q] - 1'b1;
							if (run_v_q) begin
								ev_q <= EV_RUN;
							end else begin
								ev_q <= (tl_q[tgt_q] != exe_r) ? EV_RESUME : EV_DISPATCH;
							end
						end
					end else if (!any_jobs_q) begin
						ev_q  <= EV_ALLDONE;
						who_q <= '0;
					end else begin
						ev_q      <= EV_IDLE;
						who_q     <= '0;
						clk_now_q <= now_inc;
					end
				end
				ST_SKIP: begin
					// Distance from the missed release to now, reduced below.
					dvd_q     <= clk_now_q - new_rel_q;
					rem_q     <= '0;
					div_cnt_q <= '0;
				end
				ST_DIV: begin
					dvd_q     <= dvd_q << 1;
					rem_q     <= rem_next;
					div_cnt_q <= div_cnt_q + 1'b1;
				end
				ST_FIX: begin
					// First period boundary at or after the current time.
					new_rel_q <= clk_now_q + TIME_BITS'(catch_up);
				end
				ST_WRITE: begin
					rel_q[tgt_q]  <= new_rel_q;
					dl_q[tgt_q]   <= new_rel_q + per_t;
					tl_q[tgt_q]   <= exe_r;
					late_q[tgt_q] <= 1'b0;
					if (jobs_q[tgt_q] != 16'd0) begin
						jobs_q[tgt_q] <= jobs_q[tgt_q] - 1'b1;
					end
					run_v_q <= 1'b0;
				end
				ST_OUT: ;
				default: ;
			endcase
		end
	end

	assign out_valid       = (state_q == ST_OUT);
	assign event_res       = ev_q;
	assign task_out        = who_q;
	assign now             = 32'(clk_now_q);
	assign deadline_missed = miss_flag_q;
	assign missed_total    = miss_q;
endmodule

/* tb/sv/tb_edf_tick_scheduler.sv */
// Self-checking testbench for the EDF tick scheduler: a scoreboard predicts every tick result.
module tb_edf_tick_scheduler
	import edf_pkg::*;
();

	// Clock, reset and the pins of the block.
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        operation;
	logic [2:0]  slot;
	logic [15:0] period;
	logic [15:0] exec_time;
	logic [15:0] job_count;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  event_res;
	logic [2:0]  task_out;
	logic [31:0] now;
	logic        deadline_missed;
	logic [15:0] missed_total;

	edf_tick_scheduler u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .slot(slot), .period(period),
		.exec_time(exec_time), .job_count(job_count),
		.out_valid(out_valid), .out_stall(out_stall),
		.event_res(event_res), .task_out(task_out), .now(now),
		.deadline_missed(deadline_missed), .missed_total(missed_total)
	);

	// One expected result item of a tick.
	typedef struct packed {
		event_t      ev;
		logic [2:0]  who;
		logic [31:0] t;
		logic        miss;
		logic [15:0] total;
	} tick_result_t;

	tick_result_t expected_q[$];

	// Shadow copy of the scheduler state. The running slot uses -1 for none.
	logic [15:0] sh_period [8];
	logic [15:0] sh_exec   [8];
	logic [15:0] sh_jobs   [8];
	logic [31:0] sh_release[8];
	logic [31:0] sh_dl     [8];
	logic [15:0] sh_left   [8];
	logic        sh_late   [8];
	int          sh_running;
	logic [31:0] sh_clock;
	logic [15:0] sh_misses;
	logic        sh_switch;

	int  mismatches;
	int  wd_cycles;
	bit  idle_enable;     // random bubbles on both sides when set
	bit  hold_receiver;   // long receiver hold-off request
	int  hold_cycles;
	int  stall_len;

	always #10 clk = ~clk;

	// Earliest-deadline released slot, lowest slot on a tie; -1 if none.
	function automatic int earliest_released();
		int best;
		best = -1;
		for (int i = 0; i < 8; i++) begin
			if (sh_jobs[i] != 0 && sh_release[i] <= sh_clock) begin
				if (best < 0 || sh_dl[i] < sh_dl[best])
					best = i;
			end
		end
		return best;
	endfunction

	// Runs one unit of the given slot and returns complete or run.
	function automatic event_t run_one_unit(int s, ref logic miss);
		sh_clock = sh_clock + 1;
		if (sh_left[s] <= 1) begin
			sh_left[s] = 0;
			if (sh_dl[s] < sh_clock) begin
				miss = 1'b1;
				sh_late[s] = 1'b1;
				if (sh_misses != 16'hFFFF)
					sh_misses++;
			end
			sh_switch = 1'b1;
			return EV_COMPLETE;
		end
		sh_left[s]--;
		return EV_RUN;
	endfunction

	// Advances the state by one tick and returns what the block should report.
	function automatic tick_result_t predict_tick();
		tick_result_t r;
		logic [31:0]  rel, per, d, n;
		int           c, s;
		logic         miss;
		event_t       ev;
		bit           done;
		miss = 1'b0;
		s = 0;
		if (sh_switch) begin
			sh_clock = sh_clock + 1;
			sh_switch = 1'b0;
			ev = EV_SWITCH;
			if (sh_running >= 0) begin
				s = sh_running;
				per = {16'h0, sh_period[s]};
				rel = sh_release[s] + per;
				// After a miss, whole periods are skipped to catch up with time.
				if (sh_late[s] && per != 0 && rel < sh_clock) begin
					d = sh_clock - rel;
					n = d / per + ((d % per) != 0 ? 1 : 0);
					rel = rel + n * per;
				end
				sh_release[s] = rel;
				sh_dl[s] = rel + per;
				sh_left[s] = sh_exec[s];
				if (sh_jobs[s] != 0)
					sh_jobs[s]--;
				sh_late[s] = 1'b0;
			end
			sh_running = -1;
		end else if (sh_running >= 0) begin
			c = earliest_released();
			s = sh_running;
			if (c >= 0 && sh_dl[c] < sh_dl[sh_running]) begin
				ev = EV_PREEMPT;
				sh_running = -1;
				sh_clock = sh_clock + 1;
			end else begin
				ev = run_one_unit(sh_running, miss);
			end
		end else begin
			c = earliest_released();
			if (c >= 0) begin
				sh_running = c;
				s = c;
				ev = (sh_left[c] != sh_exec[c]) ? EV_RESUME : EV_DISPATCH;
				if (run_one_unit(c, miss) == EV_COMPLETE)
					ev = EV_COMPLETE;
			end else begin
				done = 1;
				for (int i = 0; i < 8; i++)
					if (sh_jobs[i] != 0)
						done = 0;
				if (done) begin
					ev = EV_ALLDONE;
				end else begin
					ev = EV_IDLE;
					sh_clock = sh_clock + 1;
				end
			end
		end
		r.ev = ev;
		r.who = s[2:0];
		r.t = sh_clock;
		r.miss = miss;
		r.total = sh_misses;
		return r;
	endfunction

	// Applies a load to the shadow state.
	function automatic void predict_load(int s, logic [15:0] p, logic [15:0] e,
			logic [15:0] j);
		sh_period[s] = p;
		sh_exec[s] = e;
		sh_jobs[s] = j;
		sh_release[s] = 0;
		sh_dl[s] = {16'h0, p};
		sh_left[s] = e;
		sh_late[s] = 1'b0;
		if (sh_running == s) begin
			sh_running = -1;
			sh_switch = 1'b0;
		end
	endfunction

	// Sends one item, with an optional random bubble first, and predicts its effect.
	// Valid stays high after the item so that items can follow back to back;
	// a bubble or the drain drops it.
	task automatic send_item(logic op, logic [2:0] s, logic [15:0] p,
			logic [15:0] e, logic [15:0] j);
		tick_result_t res;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		slot <= s;
		period <= p;
		exec_time <= e;
		job_count <= j;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (op == OP_LOAD) begin
			predict_load(s, p, e, j);
		end else begin
			res = predict_tick();
			expected_q = {expected_q, res};
		end
	endtask

	task automatic load_task(int s, int p, int e, int j);
		send_item(OP_LOAD, s[2:0], p[15:0], e[15:0], j[15:0]);
	endtask

	task automatic tick(int count);
		repeat (count)
			send_item(OP_TICK, 3'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom));
	endtask

	// Waits for all results, then lets the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Clears every slot so the next phase starts from an empty task set.
	task automatic clear_all_slots();
		for (int i = 0; i < 8; i++)
			load_task(i, 1, 1, 0);
	endtask

	// Directed case: two tasks, deadline order, preemption and all done.
	task automatic test_basic_schedule();
		load_task(0, 10, 3, 2);
		load_task(1, 4, 1, 3);
		tick(26);
		drain();
	endtask

	// Directed case: an overloaded set that misses deadlines and skips periods.
	task automatic test_missed_deadlines();
		clear_all_slots();
		load_task(2, 3, 5, 3);
		load_task(3, 2, 2, 2);
		tick(24);
		drain();
	endtask

	// Directed case: field extremes, exec time zero, period zero, busy reload.
	task automatic test_field_extremes();
		clear_all_slots();
		load_task(7, 65535, 65535, 65535);
		load_task(4, 0, 0, 3);
		load_task(5, 1, 1, 1);
		tick(6);
		load_task(7, 2, 2, 1);   // reloading the slot that may be running
		tick(8);
		clear_all_slots();
		tick(3);                 // all done with every slot empty
		drain();
	endtask

	// Random phases: mostly well-formed task sets followed by many ticks.
	task automatic test_random_schedules();
		int items;
		int n;
		items = 0;
		while (items < 1450) begin
			clear_all_slots();
			items += 8;
			n = $urandom_range(1, 5);
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(0, 19) == 0)
					load_task($urandom_range(0, 7), $urandom, $urandom, $urandom_range(0, 3));
				else
					load_task($urandom_range(0, 7), $urandom_range(0, 12),
						$urandom_range(0, 6), $urandom_range(0, 4));
			end
			items += n;
			for (int k = 0; k < 60; k++) begin
				// Occasional reload in the middle of a run exercises busy slots.
				if ($urandom_range(0, 29) == 0)
					load_task($urandom_range(0, 7), $urandom_range(0, 12),
						$urandom_range(0, 6), $urandom_range(0, 4));
				else
					tick(1);
				items++;
			end
			// The final stretch runs without any idling.
			if (items > 1250)
				idle_enable = 0;
			drain();
		end
	endtask

	// Receiver holds off for a long time while ticks wait at the input.
	task automatic test_output_backpressure();
		clear_all_slots();
		load_task(0, 5, 2, 10);
		load_task(1, 7, 3, 10);
		hold_cycles = 300;
		hold_receiver = 1;
		tick(40);
		drain();
	endtask

	// Receiver side: random stall bursts, or a long counted hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_receiver) begin
			out_stall <= 1'b1;
			if (hold_cycles == 0) begin
				hold_receiver <= 1'b0;
				out_stall <= 1'b0;
			end else begin
				hold_cycles <= hold_cycles - 1;
			end
		end else if (idle_enable && !out_stall && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			stall_len <= $urandom_range(1, 16);
		end else if (out_stall) begin
			if (stall_len <= 1)
				out_stall <= 1'b0;
			stall_len <= stall_len - 1;
		end
	end

	// Result checker: every accepted result is matched against the oldest expectation.
	always @(posedge clk) begin
		tick_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: ev=%0d task=%0d now=%0d", event_res,
						task_out, now);
			end else begin
				e = expected_q.pop_front();
				if (event_res !== e.ev || task_out !== e.who || now !== e.t ||
						deadline_missed !== e.miss || missed_total !== e.total) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: exp ev=%0d task=%0d now=%0d miss=%0d tot=%0d",
							e.ev, e.who, e.t, e.miss, e.total);
						$display("          got ev=%0d task=%0d now=%0d miss=%0d tot=%0d",
							event_res, task_out, now, deadline_missed, missed_total);
					end
				end
			end
		end
	end

	// Watchdog: ends the run when nothing is accepted for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			wd_cycles <= 0;
		else
			wd_cycles <= wd_cycles + 1;
		if (wd_cycles > 20000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		clk = 0;
		arst_n = 0;
		in_valid = 0;
		operation = 0;
		slot = 0;
		period = 0;
		exec_time = 0;
		job_count = 0;
		mismatches = 0;
		wd_cycles = 0;
		idle_enable = 1;
		hold_receiver = 0;
		hold_cycles = 0;
		stall_len = 0;
		for (int i = 0; i < 8; i++) begin
			sh_period[i] = 0;
			sh_exec[i] = 0;
			sh_jobs[i] = 0;
			sh_release[i] = 0;
			sh_dl[i] = 0;
			sh_left[i] = 0;
			sh_late[i] = 0;
		end
		sh_running = -1;
		sh_clock = 0;
		sh_misses = 0;
		sh_switch = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_schedule();
		test_missed_deadlines();
		test_field_extremes();
		test_output_backpressure();
		test_random_schedules();

		if (expected_q.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
